// File: design/sha_pkg.sv
// package for the segment heap allocator: sizes, kind and status codes
// no dependencies
package sha_pkg;
  localparam int unsigned HeapBytesDef   = 65536;
  localparam int unsigned MaxSegmentsDef = 64;
  localparam int unsigned HeaderBytesDef = 40;
  localparam int unsigned MinRequest     = 20;
  localparam int unsigned SplitSlack     = 40;

  localparam logic [1:0] KIND_ALLOC  = 2'd0;
  localparam logic [1:0] KIND_FREE   = 2'd1;
  localparam logic [1:0] KIND_RESET  = 2'd2;
  localparam logic [1:0] KIND_REPORT = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NULL    = 3'd1;
  localparam logic [2:0] ST_NOSPACE = 3'd2;
  localparam logic [2:0] ST_DOUBLE  = 3'd3;
  localparam logic [2:0] ST_UNKNOWN = 3'd4;
endpackage

// File: design/sha_ram.sv
// generic ram with one write port and one registered read port
// no dependencies
module sha_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: design/segment_heap_allocator.sv
// segment heap allocator top level: sequencer around one segment table ram
// depends on sha_pkg and sha_ram
//
// The block works on one transaction at a time. The segment table (start,
// capacity, free mark) lives in one synchronous ram read and written one
// entry per cycle. An allocate scans the table, then on a split shifts every
// entry above the hit up by one; a free scans for the address and, on a
// merge, shifts the entries above down. A leak report scans once. Reset heap
// and null requests skip the scan and go straight to the done state. Results
// go into an output register, and the next transaction is accepted once the
// sequencer is idle and the pending result is not stalled. No clearing
// pass after reset is needed: table entries at or above the segment count
// are never used.
module segment_heap_allocator
  import sha_pkg::*;
#(
  parameter int unsigned HeapBytes   = HeapBytesDef,
  parameter int unsigned MaxSegments = MaxSegmentsDef,
  parameter int unsigned HeaderBytes = HeaderBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [16:0] request_bytes_i,
  input  logic [15:0] user_address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [15:0] granted_address_o,
  output logic signed [17:0] accounted_bytes_o,
  output logic [31:0] alloc_calls_o,
  output logic [31:0] free_calls_o,
  output logic [6:0]  live_segments_o,
  output logic [16:0] live_bytes_o
);
  localparam int unsigned IdxW = $clog2(MaxSegments);
  localparam int unsigned CntW = $clog2(MaxSegments + 1);
  // addresses and sizes kept 33 bits wide so any heap size fits
  localparam int unsigned AW = 33;
  localparam int unsigned EntW = 2 * AW + 1;
  localparam logic [AW-1:0] Hdr  = AW'(HeaderBytes);
  localparam logic [AW-1:0] Heap = AW'(HeapBytes);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxSegments);

  typedef struct packed {
    logic [AW-1:0] start;
    logic [AW-1:0] cap;
    logic          free;
  } entry_t;

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SRD    = 4'd1;  // scan: issue read
  localparam logic [3:0] S_SCHK   = 4'd2;  // scan: examine data
  localparam logic [3:0] S_DECIDE = 4'd3;
  localparam logic [3:0] S_URD    = 4'd4;  // shift up: read k-1
  localparam logic [3:0] S_UWR    = 4'd5;  // shift up: write k
  localparam logic [3:0] S_SPLIT  = 4'd6;
  localparam logic [3:0] S_FPREV  = 4'd7;  // free: read neighbours
  localparam logic [3:0] S_FPCHK  = 4'd8;
  localparam logic [3:0] S_FNCHK  = 4'd9;
  localparam logic [3:0] S_DRD    = 4'd10; // shift down: read k+stop
  localparam logic [3:0] S_DWR    = 4'd11; // shift down: write k
  localparam logic [3:0] S_DONE   = 4'd12;
  localparam logic [3:0] S_FNRD   = 4'd13;

  logic [3:0]      state_q, state_d;
  logic            fit_q;
  logic [1:0]      kind_q;
  logic [AW-1:0]   need_q, addr_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [AW-1:0]   top_q, top_d;
  logic [17:0]     total_q, total_d;
  logic [31:0]     acnt_q, acnt_d, fcnt_q, fcnt_d;
  logic [CntW-1:0] k_q, k_d;          // scan / shift position
  logic [CntW-1:0] hit_q, hit_d;
  logic            found_q, found_d;
  entry_t          hent_q, hent_d;    // hit entry copy
  entry_t          aux_q, aux_d;      // previous neighbour entry
  logic [CntW-1:0] stop_q, stop_d;    // shift-down distance
  logic            mnext_q, mnext_d;  // merge with next pending
  logic [CntW-1:0] lcnt_q, lcnt_d;
  logic [AW-1:0]   lbytes_q, lbytes_d;
  logic [2:0]      st_q, st_d;
  logic [AW-1:0]   gr_q, gr_d;

  logic            ovalid_q;
  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  entry_t          wdata, rdata;
  logic [EntW-1:0] rbits;

  assign rdata = entry_t'(rbits);

  sha_ram #(.Width(EntW), .Depth(MaxSegments)) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (EntW'(wdata)),
    .raddr_i (raddr),
    .rdata_o (rbits)
  );

  wire accept = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE) || (ovalid_q && out_stall_i);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; top_d = top_q; total_d = total_q;
    acnt_d = acnt_q; fcnt_d = fcnt_q; k_d = k_q; hit_d = hit_q;
    found_d = found_q; hent_d = hent_q; aux_d = aux_q; stop_d = stop_q;
    mnext_d = mnext_q; lcnt_d = lcnt_q; lbytes_d = lbytes_q;
    st_d = st_q; gr_d = gr_q;
    we = 1'b0; waddr = k_q[IdxW-1:0]; wdata = hent_q;
    raddr = k_q[IdxW-1:0];
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          st_d = ST_OK; gr_d = '0; lcnt_d = '0; lbytes_d = '0;
          k_d = '0; found_d = 1'b0; hit_d = '0;
          state_d = S_SRD;
          case (kind_i)
            KIND_ALLOC: if (request_bytes_i == '0) begin
              st_d = ST_NULL; state_d = S_DONE;
            end
            KIND_FREE: if (user_address_i == '0) begin
              st_d = ST_NULL; state_d = S_DONE;
            end
            KIND_RESET: begin
              cnt_d = '0; top_d = '0; total_d = '0; acnt_d = '0; fcnt_d = '0;
              state_d = S_DONE;
            end
            default: ;
          endcase
        end
      end
      S_SRD: begin
        state_d = (k_q < cnt_q) ? S_SCHK : S_DECIDE;
      end
      S_SCHK: begin
        k_d = k_q + 1'b1;
        state_d = S_SRD;
        raddr = k_d[IdxW-1:0];
        case (kind_q)
          KIND_ALLOC: begin
            if (rdata.free && rdata.cap >= need_q &&
                (!found_q || (fit_q && rdata.cap < hent_q.cap))) begin
              found_d = 1'b1; hit_d = k_q; hent_d = rdata;
              if (!fit_q) state_d = S_DECIDE;
            end
          end
          KIND_FREE: begin
            if (rdata.start + Hdr == addr_q) begin
              found_d = 1'b1; hit_d = k_q; hent_d = rdata;
              state_d = S_DECIDE;
            end
          end
          default: begin
            if (!rdata.free) begin
              lcnt_d = lcnt_q + 1'b1;
              lbytes_d = lbytes_q + Hdr + rdata.cap;
            end
          end
        endcase
      end
      S_DECIDE: begin
        state_d = S_DONE;
        case (kind_q)
          KIND_ALLOC: begin
            if (found_q) begin
              acnt_d = acnt_q + 1'b1;
              total_d = total_q + need_q[17:0];
              gr_d = hent_q.start + Hdr;
              if (hent_q.cap > need_q + Hdr + AW'(SplitSlack) && cnt_q < MaxCnt) begin
                k_d = cnt_q; state_d = S_URD;
              end else begin
                we = 1'b1; waddr = hit_q[IdxW-1:0];
                wdata = hent_q; wdata.free = 1'b0;
              end
            end else if (cnt_q >= MaxCnt || top_q + Hdr + need_q > Heap) begin
              st_d = ST_NOSPACE;
            end else begin
              we = 1'b1; waddr = cnt_q[IdxW-1:0];
              wdata.start = top_q; wdata.cap = need_q; wdata.free = 1'b0;
              cnt_d = cnt_q + 1'b1; top_d = top_q + Hdr + need_q;
              acnt_d = acnt_q + 1'b1;
              total_d = total_q + need_q[17:0];
              gr_d = top_q + Hdr;
            end
          end
          KIND_FREE: begin
            if (!found_q) st_d = ST_UNKNOWN;
            else if (hent_q.free) st_d = ST_DOUBLE;
            else begin
              fcnt_d = fcnt_q + 1'b1;
              total_d = total_q - hent_q.cap[17:0];
              hent_d.free = 1'b1;
              k_d = hit_q; state_d = S_FPREV;
              raddr = (hit_q == '0) ? '0 : IdxW'(hit_q - 1'b1);
            end
          end
          default: begin
            lcnt_d = lcnt_q;
          end
        endcase
      end
      S_URD: begin
        // move entries hit+1..cnt-1 up by one, from the top down
        if (k_q > hit_q + 1'b1) begin
          raddr = IdxW'(k_q - 1'b1); state_d = S_UWR;
        end else state_d = S_SPLIT;
      end
      S_UWR: begin
        we = 1'b1; waddr = k_q[IdxW-1:0]; wdata = rdata;
        k_d = k_q - 1'b1; state_d = S_URD;
      end
      S_SPLIT: begin
        we = 1'b1; waddr = IdxW'(hit_q + 1'b1);
        wdata.start = hent_q.start + Hdr + need_q;
        wdata.cap = hent_q.cap - Hdr - need_q;
        wdata.free = 1'b1;
        hent_d.cap = need_q; hent_d.free = 1'b0;
        cnt_d = cnt_q + 1'b1;
        state_d = S_DONE;
      end
      S_FPREV: begin
        // rdata holds the previous entry; issue read of next entry
        aux_d = rdata;
        raddr = IdxW'(hit_q + 1'b1);
        state_d = S_FPCHK;
      end
      S_FPCHK: begin
        // keep the next entry's address on the read port
        raddr = IdxW'(hit_q + 1'b1);
        state_d = S_FNRD;
      end
      S_FNRD: begin
        // rdata now holds the next entry
        mnext_d = (hit_q + 1'b1 < cnt_q) && rdata.free;
        if (mnext_d) hent_d.cap = hent_q.cap + Hdr + rdata.cap;
        state_d = S_FNCHK;
      end
      S_FNCHK: begin
        // fold into previous free entry if any, then compact the table
        if (hit_q != '0 && aux_q.free) begin
          hent_d = aux_q; hent_d.cap = aux_q.cap + Hdr + hent_q.cap;
          hit_d = hit_q - 1'b1;
          stop_d = CntW'(mnext_q) + 1'b1;
        end else stop_d = CntW'(mnext_q);
        state_d = S_DRD;
        k_d = hit_d + 1'b1;
      end
      S_DRD: begin
        // shift the rest down by stop entries, then write the merged entry
        if (stop_q == '0) begin
          we = 1'b1; waddr = hit_q[IdxW-1:0]; wdata = hent_q;
          state_d = S_DONE;
        end else if (k_q + stop_q < cnt_q) begin
          raddr = IdxW'(k_q + stop_q); state_d = S_DWR;
        end else begin
          cnt_d = cnt_q - stop_q; stop_d = '0;
        end
      end
      S_DWR: begin
        we = 1'b1; waddr = k_q[IdxW-1:0]; wdata = rdata;
        k_d = k_q + 1'b1; state_d = S_DRD;
      end
      S_DONE: begin
        if (kind_q == KIND_ALLOC && st_q == ST_OK && found_q) begin
          we = 1'b1; waddr = hit_q[IdxW-1:0]; wdata = hent_q; wdata.free = 1'b0;
        end
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; fit_q <= 1'b0; cnt_q <= '0; top_q <= '0;
      total_q <= '0; acnt_q <= '0; fcnt_q <= '0; ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; top_q <= top_d; total_q <= total_d;
      acnt_q <= acnt_d; fcnt_q <= fcnt_d;
      if (cfg_valid_i && cfg_ready_o) fit_q <= cfg_data_i;
      // a new result never lands while the previous one is still held
      ovalid_q <= (state_q == S_DONE) || (ovalid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d; hit_q <= hit_d; found_q <= found_d; hent_q <= hent_d;
    aux_q <= aux_d; stop_q <= stop_d; mnext_q <= mnext_d;
    lcnt_q <= lcnt_d; lbytes_q <= lbytes_d; st_q <= st_d; gr_q <= gr_d;
    if (accept) begin
      kind_q <= kind_i;
      need_q <= (request_bytes_i < 17'(MinRequest)) ? AW'(MinRequest)
                                                     : AW'(request_bytes_i);
      addr_q <= AW'(user_address_i);
    end
    if (state_q == S_DONE) begin
      status_o          <= st_q;
      granted_address_o <= gr_q[15:0];
      accounted_bytes_o <= total_q;
      alloc_calls_o     <= acnt_q;
      free_calls_o      <= fcnt_q;
      live_segments_o   <= 7'(lcnt_q);
      live_bytes_o      <= lbytes_q[16:0];
    end
  end
endmodule

// File: design/sha_checker.sv
// port-level checker for the segment heap allocator, bound to the top level
// depends on sha_pkg
module sha_port_checker
  import sha_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  status_o,
  input logic [15:0] granted_address_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o))
    else $error("stalled result changed");
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= ST_UNKNOWN)
    else $error("bad status code");
  a_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> granted_address_o == '0)
    else $error("address granted on error");
  a_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("request taken while result stalled");
endmodule

bind segment_heap_allocator sha_port_checker u_sha_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_stall_o(in_stall_o), .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i), .status_o(status_o),
  .granted_address_o(granted_address_o)
);

// File: verif/sha_checker.sv
// checker for the segment heap allocator: watches the config, request and
// result channels, predicts each result and compares it field by field
// depends on sha_pkg
module sha_checker
  import sha_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic               cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [1:0]         kind_i,
  input  logic [16:0]        request_bytes_i,
  input  logic [15:0]        user_address_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [2:0]         status_i,
  input  logic [15:0]        granted_address_i,
  input  logic signed [17:0] accounted_bytes_i,
  input  logic [31:0]        alloc_calls_i,
  input  logic [31:0]        free_calls_i,
  input  logic [6:0]         live_segments_i,
  input  logic [16:0]        live_bytes_i,
  output int                 pending_o,
  output int                 failures_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Slots = MaxSegmentsDef;
  localparam int Hdr   = HeaderBytesDef;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] granted;
    logic [17:0] total;
    logic [31:0] allocs;
    logic [31:0] frees;
    logic [6:0]  live_n;
    logic [16:0] live_b;
  } heap_result_t;

  heap_result_t result_q[$];

  int          seg_base [Slots];
  int          seg_cap  [Slots];
  bit          seg_free [Slots];
  int          seg_count;
  int          heap_top;
  logic [17:0] byte_total;
  logic [31:0] n_alloc, n_free;
  bit          smallest_fit;

  function automatic void clear_heap();
    seg_count  = 0;
    heap_top   = 0;
    byte_total = '0;
    n_alloc    = '0;
    n_free     = '0;
  endfunction

  // removes entry pos, entries above move down
  function automatic void drop_slot(int pos);
    for (int k = pos; k + 1 < seg_count; k++) begin
      seg_base[k] = seg_base[k + 1];
      seg_cap[k]  = seg_cap[k + 1];
      seg_free[k] = seg_free[k + 1];
    end
    seg_count--;
  endfunction

  function automatic heap_result_t predict_heap(logic [1:0] kind, int req, int addr);
    heap_result_t r;
    int need, hit, best, i;
    r = '0;
    r.status = ST_OK;
    case (kind)
      KIND_ALLOC: begin
        need = (req < MinRequest) ? MinRequest : req;
        hit  = seg_count;
        best = 0;
        if (req == 0) r.status = ST_NULL;
        else begin
          for (i = 0; i < seg_count; i++) begin
            if (seg_free[i] && seg_cap[i] >= need) begin
              if (!smallest_fit) begin
                hit = i;
                break;
              end
              if (hit == seg_count || seg_cap[i] < best) begin
                hit  = i;
                best = seg_cap[i];
              end
            end
          end
          if (hit < seg_count) begin
            // split only while the table has a spare slot
            if (seg_cap[hit] > need + Hdr + SplitSlack && seg_count < Slots) begin
              for (int k = seg_count; k > hit + 1; k--) begin
                seg_base[k] = seg_base[k - 1];
                seg_cap[k]  = seg_cap[k - 1];
                seg_free[k] = seg_free[k - 1];
              end
              seg_count++;
              seg_base[hit + 1] = seg_base[hit] + Hdr + need;
              seg_cap[hit + 1]  = seg_cap[hit] - Hdr - need;
              seg_free[hit + 1] = 1'b1;
              seg_cap[hit]      = need;
            end
            seg_free[hit] = 1'b0;
          end else if (seg_count >= Slots || heap_top + Hdr + need > HeapBytesDef) begin
            r.status = ST_NOSPACE;
          end else begin
            seg_base[hit] = heap_top;
            seg_cap[hit]  = need;
            seg_free[hit] = 1'b0;
            seg_count++;
            heap_top += Hdr + need;
          end
          if (r.status == ST_OK) begin
            n_alloc++;
            byte_total += need[17:0];
            r.granted = 16'(seg_base[hit] + Hdr);
          end
        end
      end
      KIND_FREE: begin
        if (addr == 0) r.status = ST_NULL;
        else begin
          for (i = 0; i < seg_count; i++)
            if (seg_base[i] + Hdr == addr) break;
          if (i >= seg_count) r.status = ST_UNKNOWN;
          else if (seg_free[i]) r.status = ST_DOUBLE;
          else begin
            seg_free[i] = 1'b1;
            n_free++;
            byte_total -= 18'(seg_cap[i]);
            if (i > 0 && seg_free[i - 1]) begin
              seg_cap[i - 1] += Hdr + seg_cap[i];
              drop_slot(i);
              i--;
            end
            if (i + 1 < seg_count && seg_free[i + 1]) begin
              seg_cap[i] += Hdr + seg_cap[i + 1];
              drop_slot(i + 1);
            end
          end
        end
      end
      KIND_RESET: clear_heap();
      default: begin
        for (i = 0; i < seg_count; i++)
          if (!seg_free[i]) begin
            r.live_n++;
            r.live_b += 17'(Hdr + seg_cap[i]);
          end
      end
    endcase
    r.total  = byte_total;
    r.allocs = n_alloc;
    r.frees  = n_free;
    return r;
  endfunction

  heap_result_t seen, want;

  assign seen = '{status_i, granted_address_i, accounted_bytes_i, alloc_calls_i,
                  free_calls_i, live_segments_i, live_bytes_i};

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_heap();
      smallest_fit = 1'b0;
      result_q.delete();
      failures_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) smallest_fit = cfg_data_i;
      if (in_valid_i && !in_stall_i)
        result_q.push_back(predict_heap(kind_i, int'(request_bytes_i),
                                        int'(user_address_i)));
      if (out_valid_i && !out_stall_i) begin
        if (result_q.size() == 0) begin
          $display("%0t: result transaction with nothing expected, got %p", $time, seen);
          failures_o++;
        end else begin
          want = result_q.pop_front();
          if (want != seen) begin
            $display("%0t: result mismatch, expected %p, actual %p", $time, want, seen);
            failures_o++;
          end
        end
      end
      pending_o = result_q.size();
    end
  end
endmodule

// File: verif/segment_heap_allocator_test.sv
// testbench top for the segment heap allocator: clock, reset, stimulus
// depends on sha_pkg, sha_checker and the segment_heap_allocator rtl
module segment_heap_allocator_test
  import sha_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0, cfg_data_i = 1'b0;
  logic               cfg_ready_o;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         kind_i = KIND_REPORT;
  logic [16:0]        request_bytes_i = '0;
  logic [15:0]        user_address_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [2:0]         status_o;
  logic [15:0]        granted_address_o;
  logic signed [17:0] accounted_bytes_o;
  logic [31:0]        alloc_calls_o, free_calls_o;
  logic [6:0]         live_segments_o;
  logic [16:0]        live_bytes_o;
  int                 pending, failures;
  int                 stall_pct = 0;
  logic [15:0]        granted_pool[$];

  // idle wait after the last result, covering any tail work of the block
  localparam int DrainCycles = 300;

  always #5 clk_i = ~clk_i;

  segment_heap_allocator u_top (.*);

  sha_checker u_check (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .kind_i, .request_bytes_i,
    .user_address_i, .out_valid_i(out_valid_o), .out_stall_i,
    .status_i(status_o), .granted_address_i(granted_address_o),
    .accounted_bytes_i(accounted_bytes_o), .alloc_calls_i(alloc_calls_o),
    .free_calls_i(free_calls_o), .live_segments_i(live_segments_o),
    .live_bytes_i(live_bytes_o), .pending_o(pending), .failures_o(failures)
  );

  // mostly back to back or short gaps, now and then a long one
  function automatic int gap_len();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  // receiver back-pressure; stall density changes in stretches, zero included
  always @(negedge clk_i) begin
    if ($urandom_range(199) == 0) begin
      case ($urandom_range(3))
        0, 1: stall_pct = 0;
        2:    stall_pct = 30;
        default: stall_pct = 80;
      endcase
    end
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // granted addresses become free targets for later stimulus
  always @(posedge clk_i)
    if (out_valid_o && !out_stall_i && status_o == ST_OK && granted_address_o != 0) begin
      granted_pool.push_back(granted_address_o);
      if (granted_pool.size() > 128) void'(granted_pool.pop_front());
    end

  // one request transaction; valid stays high into the next call if no gap
  task automatic send_req(logic [1:0] kind, logic [16:0] req, logic [15:0] addr);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    kind_i          = kind;
    request_bytes_i = req;
    user_address_i  = addr;
    in_valid_i      = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // wait for every result, then for any tail work of the block
  task automatic drain();
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_fit_mode(logic mode);
    cfg_valid_i = 1'b1;
    cfg_data_i  = mode;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic random_req();
    int roll;
    logic [16:0] req;
    logic [15:0] addr;
    roll = $urandom_range(999);
    addr = 16'($urandom);
    req  = 17'($urandom_range(65536));
    if (roll < 500) begin
      roll = $urandom_range(99);
      if (roll < 70)      req = 17'($urandom_range(1, 100));
      else if (roll < 90) req = 17'($urandom_range(101, 2000));
      else if (roll < 97) req = 17'($urandom_range(2001, 20000));
      else if (roll < 98) req = '0;
      send_req(KIND_ALLOC, req, addr);
    end else if (roll < 860) begin
      if (granted_pool.size() > 0 && $urandom_range(99) < 85)
        addr = granted_pool[$urandom_range(granted_pool.size() - 1)];
      send_req(KIND_FREE, req, addr);
    end else if (roll < 985) send_req(KIND_REPORT, req, addr);
    else send_req(KIND_RESET, req, addr);
  endtask

  initial begin
    #20ms;
    $display("[segment_heap_allocator] ERROR");
    $finish;
  end

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: null, minimum raise, extremes, double free, unknown, merge
    write_fit_mode(1'b0);
    send_req(KIND_ALLOC, 17'd0, 16'hffff);
    send_req(KIND_ALLOC, 17'd1, 16'd0);
    send_req(KIND_ALLOC, 17'd20, 16'd0);
    send_req(KIND_ALLOC, 17'd500, 16'd0);
    send_req(KIND_ALLOC, 17'd100, 16'd0);
    send_req(KIND_FREE, 17'h1ffff & 17'd65536, 16'd160);
    send_req(KIND_FREE, 17'd0, 16'd160);
    send_req(KIND_FREE, 17'd0, 16'd161);
    send_req(KIND_FREE, 17'd0, 16'd0);
    send_req(KIND_FREE, 17'd0, 16'hffff);
    send_req(KIND_ALLOC, 17'd30, 16'd0);
    send_req(KIND_ALLOC, 17'd65536, 16'd0);
    send_req(KIND_FREE, 17'd0, 16'd40);
    send_req(KIND_FREE, 17'd0, 16'd100);
    send_req(KIND_REPORT, 17'd0, 16'd0);
    drain();
    write_fit_mode(1'b1);
    send_req(KIND_ALLOC, 17'd20, 16'd0);
    send_req(KIND_ALLOC, 17'd200, 16'd0);
    send_req(KIND_REPORT, 17'd65536, 16'hffff);
    send_req(KIND_RESET, 17'd65536, 16'hffff);

    // full table: a split that finds no spare slot grants the segment whole
    send_req(KIND_ALLOC, 17'd1000, 16'd0);
    repeat (63) send_req(KIND_ALLOC, 17'd1, 16'd0);
    send_req(KIND_ALLOC, 17'd1, 16'd0);
    send_req(KIND_FREE, 17'd0, 16'd40);
    send_req(KIND_ALLOC, 17'd20, 16'd0);
    send_req(KIND_REPORT, 17'd0, 16'd0);
    send_req(KIND_RESET, 17'd0, 16'd0);
    drain();

    // random phases, fit mode toggled between them while the block is idle
    for (int phase = 0; phase < 5; phase++) begin
      write_fit_mode(phase[0]);
      repeat (250) random_req();
      drain();
    end

    if (failures == 0) begin
      $display("[segment_heap_allocator] OK");
    end else begin
      $display("[segment_heap_allocator] ERROR");
    end
    $finish;
  end
endmodule
